### rtl/ijap_pkg.sv
// shared types, codes and the step tables of the joystick/accelerometer poll sequencer
package ijap_pkg;

	// command codes on the input channel
	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;

	// status codes reported by the bus master
	localparam logic [2:0] MS_IDLE     = 3'd0;
	localparam logic [2:0] MS_RX_READY = 3'd1;
	localparam logic [2:0] MS_TX_READY = 3'd2;
	localparam logic [2:0] MS_ADDR_NAK = 3'd3;
	localparam logic [2:0] MS_DATA_NAK = 3'd4;

	// actions handed to the bus master
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_CONT_TX = 3'd2;
	localparam logic [2:0] ACT_CONT_RX = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;

	localparam logic [6:0] DEV_ADDR_RST = 7'd82;
	localparam logic [4:0] INIT_LEN     = 5'd8;
	localparam logic [4:0] READ_LEN     = 5'd11;
	localparam int unsigned RX_BYTES    = 6;

	typedef enum logic [2:0] {
		OP_START_WR,
		OP_START_RD,
		OP_TX,
		OP_STOP,
		OP_RX
	} seq_op_kind_t;

	typedef struct packed {
		seq_op_kind_t kind;
		logic [7:0]   byte_val;
	} seq_op_t;

	// sequencer control state
	typedef struct packed {
		logic       running;
		logic       read_seq;
		logic [4:0] step;
	} seq_ctl_t;

	// what one step produces
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       done;
		logic       success;
		logic       decode;
		logic       rx_we;
		logic [2:0] rx_idx;
	} step_res_t;

	function automatic logic [4:0] seq_len(input logic read_seq);
		seq_len = read_seq ? READ_LEN : INIT_LEN;
	endfunction

	function automatic seq_op_t seq_lookup(input logic read_seq, input logic [4:0] step);
		seq_op_t op;
		op = '{kind: OP_STOP, byte_val: 8'h00};
		if (read_seq) begin
			unique case (step)
				5'd0:    op = '{kind: OP_START_WR, byte_val: 8'h00};
				5'd1:    op = '{kind: OP_TX,       byte_val: 8'h00};
				5'd2:    op = '{kind: OP_STOP,     byte_val: 8'h00};
				5'd3:    op = '{kind: OP_START_RD, byte_val: 8'h00};
				5'd4:    op = '{kind: OP_RX,       byte_val: 8'd0};
				5'd5:    op = '{kind: OP_RX,       byte_val: 8'd1};
				5'd6:    op = '{kind: OP_RX,       byte_val: 8'd2};
				5'd7:    op = '{kind: OP_RX,       byte_val: 8'd3};
				5'd8:    op = '{kind: OP_RX,       byte_val: 8'd4};
				5'd9:    op = '{kind: OP_RX,       byte_val: 8'd5};
				default: op = '{kind: OP_STOP,     byte_val: 8'h00};
			endcase
		end else begin
			unique case (step)
				5'd0:    op = '{kind: OP_START_WR, byte_val: 8'h00};
				5'd1:    op = '{kind: OP_TX,       byte_val: 8'hf0};
				5'd2:    op = '{kind: OP_TX,       byte_val: 8'h55};
				5'd3:    op = '{kind: OP_STOP,     byte_val: 8'h00};
				5'd4:    op = '{kind: OP_START_WR, byte_val: 8'h00};
				5'd5:    op = '{kind: OP_TX,       byte_val: 8'hfb};
				5'd6:    op = '{kind: OP_TX,       byte_val: 8'h00};
				default: op = '{kind: OP_STOP,     byte_val: 8'h00};
			endcase
		end
		return op;
	endfunction

endpackage

### rtl/ijap_step.sv
// one poll sequencer step: starts a sequence or checks a status, picks next action
module ijap_step
	import ijap_pkg::*;
(
	input  seq_ctl_t   ctl,
	input  logic [1:0] command,
	input  logic [2:0] master_state,
	input  logic [6:0] device_address,
	output seq_ctl_t   ctl_nxt,
	output step_res_t  res
);

	seq_op_t    op;
	logic [4:0] len;
	logic [4:0] step_inc;
	logic       nack;
	logic       ok;

	assign op       = seq_lookup(ctl.read_seq, ctl.step);
	assign len      = seq_len(ctl.read_seq);
	assign step_inc = ctl.step + 5'd1;
	assign nack     = (master_state == MS_ADDR_NAK) || (master_state == MS_DATA_NAK);

	always_comb begin
		unique case (op.kind) inside
			OP_START_WR, OP_START_RD: ok = (master_state == MS_IDLE);
			OP_TX:                    ok = (master_state == MS_TX_READY);
			default:                  ok = (master_state == MS_RX_READY);
		endcase
	end

	always_comb begin
		ctl_nxt = ctl;
		res     = '0;
		case (command) inside
			CMD_INIT, CMD_READ: begin
				ctl_nxt.running  = 1'b1;
				ctl_nxt.read_seq = command[0];
				ctl_nxt.step     = '0;
			end
			CMD_STATUS: begin
				if (ctl.running) begin
					if (ctl.step >= len) begin
						// stray step count, treat as finished
						ctl_nxt.running = 1'b0;
						ctl_nxt.step    = '0;
					end else if (op.kind == OP_STOP) begin
						res.action   = ACT_STOP;
						ctl_nxt.step = step_inc;
						if (step_inc >= len) begin
							res.done        = 1'b1;
							res.success     = 1'b1;
							res.decode      = ctl.read_seq;
							ctl_nxt.running = 1'b0;
							ctl_nxt.step    = '0;
						end
					end else if (op.kind != OP_RX && nack) begin
						// stop the bus and retry the same step
						res.action = ACT_STOP;
					end else if (!ok) begin
						res.action      = ctl.read_seq ? ACT_STOP : ACT_NONE;
						res.done        = 1'b1;
						ctl_nxt.running = 1'b0;
						ctl_nxt.step    = '0;
					end else begin
						ctl_nxt.step = step_inc;
						case (op.kind)
							OP_START_WR: begin
								res.action  = ACT_START;
								res.tx_byte = {device_address, 1'b0};
							end
							OP_START_RD: begin
								res.action  = ACT_START;
								res.tx_byte = {device_address, 1'b1};
							end
							OP_TX: begin
								res.action  = ACT_CONT_TX;
								res.tx_byte = op.byte_val;
							end
							default: begin
								res.action = ACT_CONT_RX;
								res.rx_we  = 1'b1;
								res.rx_idx = op.byte_val[2:0];
							end
						endcase
					end
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/i2c_joystick_accel_poller.sv
// top level of the joystick/accelerometer poll sequencer
//
// Sits beside an I2C master's command interface. Each input transaction is
// either a begin command (init or read sequence) or a status report from the
// master; each one yields exactly one result transaction carrying the action
// for the master, the byte to load, the done/success flags and, on the item
// that completes a read, the decoded stick, acceleration and button fields.
// The cfg channel writes the seven-bit device address (reset 82); it is
// always ready and should only be written while no transaction is pending.
// A result appears on the clock after its input is
// taken, held in the output register. Throughput is one item per cycle,
// limited by that single output register: in_ready is high while the
// register is empty or being drained in the same cycle, so a stalled
// receiver stalls the input. Reset clears the sequencer to not running,
// empties the output register and restores the address; the six received
// bytes are not cleared and are read only after a read sequence fills them.
module i2c_joystick_accel_poller
	import ijap_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [2:0] master_state,
	input  logic [7:0] read_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] action,
	output logic [7:0] tx_byte,
	output logic       done_res,
	output logic       success,
	output logic [7:0] stick_x,
	output logic [7:0] stick_y,
	output logic [9:0] accel_x,
	output logic [9:0] accel_y,
	output logic [9:0] accel_z,
	output logic       button_c,
	output logic       button_z
);

	seq_ctl_t   ctl_q;
	seq_ctl_t   ctl_nxt;
	step_res_t  res;
	logic [6:0] dev_addr_q;
	logic [7:0] rx_bytes_q [RX_BYTES];
	logic       out_valid_q;
	logic       accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	ijap_step u_step (
		.ctl            (ctl_q),
		.command        (command),
		.master_state   (master_state),
		.device_address (dev_addr_q),
		.ctl_nxt        (ctl_nxt),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= '0;
			dev_addr_q  <= DEV_ADDR_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				dev_addr_q <= cfg_data;
			end
			if (accept) begin
				ctl_q <= ctl_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.rx_we) begin
			rx_bytes_q[res.rx_idx] <= read_byte;
		end
	end

	// result register, decoded fields stay zero unless a read completes
	always_ff @(posedge clk) begin
		if (accept) begin
			action   <= res.action;
			tx_byte  <= res.tx_byte;
			done_res <= res.done;
			success  <= res.success;
			if (res.decode) begin
				stick_x  <= rx_bytes_q[0];
				stick_y  <= rx_bytes_q[1];
				accel_x  <= {rx_bytes_q[2], rx_bytes_q[5][3:2]};
				accel_y  <= {rx_bytes_q[3], rx_bytes_q[5][5:4]};
				accel_z  <= {rx_bytes_q[4], rx_bytes_q[5][7:6]};
				button_c <= rx_bytes_q[5][1];
				button_z <= rx_bytes_q[5][0];
			end else begin
				stick_x  <= '0;
				stick_y  <= '0;
				accel_x  <= '0;
				accel_y  <= '0;
				accel_z  <= '0;
				button_c <= 1'b0;
				button_z <= 1'b0;
			end
		end
	end

endmodule
